@@ hw/rtl/sfrs8_pkg.sv @@
// ----------------------------------------------------------------------------
// sfrs8_pkg
// shared types and constants of the serial frame receiver
// ----------------------------------------------------------------------------
package sfrs8_pkg;

  localparam logic [7:0]  HDR_FIRST       = 8'h55;
  localparam logic [7:0]  HDR_SECOND      = 8'hAA;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd300;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  command_code;
    logic [7:0]  protocol_version;
    logic [15:0] payload_length;
    logic [1:0]  status;
  } out_item_t;

endpackage

@@ hw/rtl/sfrs8_if.sv @@
// ----------------------------------------------------------------------------
// sfrs8 channel interfaces
// valid/ready request channels for input, result and configuration
// ----------------------------------------------------------------------------
interface sfrs8_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfrs8_out_if;
  logic        valid;
  logic        ready;
  logic        frame_end;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [7:0]  command_code;
  logic [7:0]  protocol_version;
  logic [15:0] payload_length;
  logic [1:0]  status;

  modport source (output valid, output frame_end, output payload_byte, output byte_index,
                  output command_code, output protocol_version, output payload_length,
                  output status, input ready);
  modport sink   (input valid, input frame_end, input payload_byte, input byte_index,
                  input command_code, input protocol_version, input payload_length,
                  input status, output ready);
endinterface

interface sfrs8_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/sfrs8_in_stage.sv @@
// ----------------------------------------------------------------------------
// sfrs8_in_stage
// input register holding one request until the parser takes it
// ----------------------------------------------------------------------------
module sfrs8_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfrs8_pkg::in_item_t push_item,
  output logic              can_push,
  input  logic              take,
  output logic              item_valid,
  output sfrs8_pkg::in_item_t item
);
  import sfrs8_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign can_push   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_push) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      item_r <= push_item;
    end
  end

endmodule

@@ hw/rtl/sfrs8_parser.sv @@
// ----------------------------------------------------------------------------
// sfrs8_parser
// frame state machine, checksum and idle timeout, one request per cycle unless a full result register holds a result
// ----------------------------------------------------------------------------
module sfrs8_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          timeout,
  input  logic                 item_valid,
  input  sfrs8_pkg::in_item_t  item,
  output logic                 take,
  input  logic                 slot_free,
  output logic                 res_push,
  output sfrs8_pkg::out_item_t res
);
  import sfrs8_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR1, PH_HDR2, PH_VER, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CSUM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] idle_inc;
  logic [15:0] seen_inc;
  logic [15:0] len_lo;
  logic [7:0]  b;
  logic        res_vld;

  assign b        = item.rx_byte;
  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + 16'd1;
  assign seen_inc = seen_r + 16'd1;
  assign len_lo   = {len_r[15:8], b};

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    ver_nxt   = ver_r;
    idle_nxt  = idle_r;
    res_vld   = 1'b0;
    res                  = '0;
    res.command_code     = cmd_r;
    res.protocol_version = ver_r;
    res.payload_length   = len_r;

    if (item.opcode == OP_TICK) begin
      if (phase_r != PH_HDR1) begin
        if (idle_inc > timeout) begin
          res_vld       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_TIMEOUT;
          phase_nxt     = PH_HDR1;
          idle_nxt      = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HDR1: begin
          if (b == HDR_FIRST) begin
            sum_nxt   = b;
            len_nxt   = '0;
            seen_nxt  = '0;
            cmd_nxt   = '0;
            ver_nxt   = '0;
            idle_nxt  = '0;
            phase_nxt = PH_HDR2;
          end
        end
        PH_HDR2: begin
          idle_nxt = '0;
          if (b != HDR_SECOND) begin
            phase_nxt = PH_HDR1;
          end else begin
            phase_nxt = PH_VER;
            sum_nxt   = sum_r + b;
          end
        end
        PH_VER: begin
          ver_nxt   = b;
          phase_nxt = PH_CMD;
          sum_nxt   = sum_r + b;
          idle_nxt  = '0;
        end
        PH_CMD: begin
          cmd_nxt   = b;
          phase_nxt = PH_LEN_HI;
          sum_nxt   = sum_r + b;
          idle_nxt  = '0;
        end
        PH_LEN_HI: begin
          len_nxt   = {b, 8'h00};
          phase_nxt = PH_LEN_LO;
          sum_nxt   = sum_r + b;
          idle_nxt  = '0;
        end
        PH_LEN_LO: begin
          len_nxt   = len_lo;
          seen_nxt  = '0;
          phase_nxt = (len_lo == '0) ? PH_CSUM : PH_PAYLOAD;
          sum_nxt   = sum_r + b;
          idle_nxt  = '0;
        end
        PH_PAYLOAD: begin
          res_vld          = 1'b1;
          res.payload_byte = b;
          res.byte_index   = seen_r;
          seen_nxt         = seen_inc;
          if (seen_inc == len_r) begin
            phase_nxt = PH_CSUM;
          end
          sum_nxt  = sum_r + b;
          idle_nxt = '0;
        end
        PH_CSUM: begin
          res_vld       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = (b == sum_r) ? ST_GOOD : ST_BAD_SUM;
          phase_nxt     = PH_HDR1;
          idle_nxt      = '0;
        end
        default: begin
          phase_nxt = PH_HDR1;
        end
      endcase
    end
  end

  // a request that yields nothing never waits on the result side
  assign take     = item_valid && (!res_vld || slot_free);
  assign res_push = take && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      len_r   <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
      ver_r   <= '0;
      idle_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
      ver_r   <= ver_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

@@ hw/rtl/sfrs8_out_stage.sv @@
// ----------------------------------------------------------------------------
// sfrs8_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
module sfrs8_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfrs8_pkg::out_item_t push_item,
  output logic                 slot_free,
  input  logic                 pop,
  output logic                 item_valid,
  output sfrs8_pkg::out_item_t item
);
  import sfrs8_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign slot_free  = !valid_r || pop;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && push) begin
      item_r <= push_item;
    end
  end

endmodule

@@ hw/rtl/serial_frame_receiver_sum8_unit.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum8_unit
// length-prefixed serial frame receiver with 8-bit additive checksum
//
//   channel   direction  payload
//   in_chan   sink       opcode, rx_byte
//   out_chan  source     frame_end, payload_byte, byte_index, command_code,
//                        protocol_version, payload_length, status
//   cfg_chan  sink       data = receive timeout in ms ticks
//
// one request per cycle sustained; a request's result passes from the input register
// through the parser into the result register.
// the parser state updates once per request, which sets the single-cycle rate.
// a full result register stalls only requests that produce a result.
// rst_n is synchronous; the timeout register resets to 300, cfg_ready is always high.
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum8_unit (
  input logic         clk,
  input logic         rst_n,
  sfrs8_in_if.sink    in_chan,
  sfrs8_out_if.source out_chan,
  sfrs8_cfg_if.sink   cfg_chan
);
  import sfrs8_pkg::*;

  logic [15:0] timeout_val_r;
  in_item_t    in_push_item;
  in_item_t    in_item;
  logic        in_item_valid;
  logic        take;
  logic        slot_free;
  logic        res_push;
  out_item_t   res;
  out_item_t   out_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_val_r <= TIMEOUT_RESET;
    end else if (cfg_chan.valid) begin
      timeout_val_r <= cfg_chan.data;
    end
  end

  assign in_push_item.opcode  = in_chan.opcode;
  assign in_push_item.rx_byte = in_chan.rx_byte;

  sfrs8_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_chan.valid),
    .push_item  (in_push_item),
    .can_push   (in_chan.ready),
    .take       (take),
    .item_valid (in_item_valid),
    .item       (in_item)
  );

  sfrs8_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .timeout    (timeout_val_r),
    .item_valid (in_item_valid),
    .item       (in_item),
    .take       (take),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res        (res)
  );

  sfrs8_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_item  (res),
    .slot_free  (slot_free),
    .pop        (out_chan.ready),
    .item_valid (out_chan.valid),
    .item       (out_item)
  );

  assign out_chan.frame_end        = out_item.frame_end;
  assign out_chan.payload_byte     = out_item.payload_byte;
  assign out_chan.byte_index       = out_item.byte_index;
  assign out_chan.command_code     = out_item.command_code;
  assign out_chan.protocol_version = out_item.protocol_version;
  assign out_chan.payload_length   = out_item.payload_length;
  assign out_chan.status           = out_item.status;

endmodule

@@ tb/sv/serial_frame_receiver_sum8_unit_tb.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum8_unit_tb
// self-checking bench for the serial frame receiver: a queue-fed driver sends
// bytes and ticks, an internal frame parser predicts every payload and frame
// end result, and a monitor compares them under random gaps on both sides and
// several receive timeout settings
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum8_unit_tb;
  import sfrs8_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_VERSION,
    PH_COMMAND,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECKSUM
  } parse_phase_t;

  typedef struct {
    in_item_t rq;
    bit       drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n;

  sfrs8_in_if  in_if ();
  sfrs8_out_if out_if ();
  sfrs8_cfg_if cfg_if ();

  serial_frame_receiver_sum8_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pending_t     pending_requests[$];
  out_item_t    expected_results[$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  bit           no_gaps = 1'b0;

  // parser copy
  parse_phase_t rx_phase = PH_HDR1;
  logic [15:0]  declared_len = '0;
  logic [15:0]  bytes_taken = '0;
  logic [7:0]   running_sum = '0;
  logic [7:0]   held_command = '0;
  logic [7:0]   held_version = '0;
  logic [15:0]  idle_ms = '0;
  logic [15:0]  timeout_ms = TIMEOUT_RESET;

  function automatic out_item_t frame_result(input logic fe, input logic [7:0] pb,
                                             input logic [15:0] idx, input status_t st);
    out_item_t r;
    r.frame_end        = fe;
    r.payload_byte     = pb;
    r.byte_index       = idx;
    r.command_code     = held_command;
    r.protocol_version = held_version;
    r.payload_length   = declared_len;
    r.status           = st;
    return r;
  endfunction

  task automatic add_expected(input out_item_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic parse_request(input in_item_t rq);
    bit absorb;
    absorb = 1'b0;
    if (rq.opcode == OP_TICK) begin
      if (rx_phase != PH_HDR1) begin
        if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
        if (idle_ms > timeout_ms) begin
          add_expected(frame_result(1'b1, 8'h00, 16'h0000, ST_TIMEOUT));
          rx_phase = PH_HDR1;
          idle_ms  = '0;
        end
      end
    end else begin
      case (rx_phase)
        PH_HDR1: begin
          if (rq.rx_byte == HDR_FIRST) begin
            running_sum  = rq.rx_byte;
            declared_len = '0;
            bytes_taken  = '0;
            held_command = '0;
            held_version = '0;
            idle_ms      = '0;
            rx_phase     = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (rq.rx_byte != HDR_SECOND) begin
            rx_phase = PH_HDR1;
            idle_ms  = '0;
          end else begin
            rx_phase = PH_VERSION;
            absorb   = 1'b1;
          end
        end
        PH_VERSION: begin
          held_version = rq.rx_byte;
          rx_phase     = PH_COMMAND;
          absorb       = 1'b1;
        end
        PH_COMMAND: begin
          held_command = rq.rx_byte;
          rx_phase     = PH_LEN_HI;
          absorb       = 1'b1;
        end
        PH_LEN_HI: begin
          declared_len = {rq.rx_byte, 8'h00};
          rx_phase     = PH_LEN_LO;
          absorb       = 1'b1;
        end
        PH_LEN_LO: begin
          declared_len = {declared_len[15:8], rq.rx_byte};
          bytes_taken  = '0;
          rx_phase     = (declared_len == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
          absorb       = 1'b1;
        end
        PH_PAYLOAD: begin
          add_expected(frame_result(1'b0, rq.rx_byte, bytes_taken, ST_GOOD));
          bytes_taken = bytes_taken + 16'd1;
          if (bytes_taken == declared_len) rx_phase = PH_CHECKSUM;
          absorb = 1'b1;
        end
        default: begin
          add_expected(frame_result(1'b1, 8'h00, 16'h0000,
            (rq.rx_byte == running_sum) ? ST_GOOD : ST_BAD_SUM));
          rx_phase = PH_HDR1;
          idle_ms  = '0;
        end
      endcase
      if (absorb) begin
        running_sum = running_sum + rq.rx_byte;
        idle_ms     = '0;
      end
    end
  endtask

  // request driver, predicts on every accepted request
  always @(posedge clk) begin : drive_requests
    in_item_t taken;
    pending_t nxt;
    bit       gap;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        taken.opcode  = in_if.opcode;
        taken.rx_byte = in_if.rx_byte;
        parse_request(taken);
      end
      gap = !no_gaps && ($urandom_range(0, 99) < 9);
      if (pending_requests.size() != 0 && !gap &&
          !(pending_requests[0].drain && expected_results.size() != 0)) begin
        nxt = pending_requests.pop_front();
        in_if.valid   <= 1'b1;
        in_if.opcode  <= nxt.rq.opcode;
        in_if.rx_byte <= nxt.rq.rx_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_gaps || ($urandom_range(0, 99) >= 9);
      if (out_if.valid && out_if.ready) begin
        got.frame_end        = out_if.frame_end;
        got.payload_byte     = out_if.payload_byte;
        got.byte_index       = out_if.byte_index;
        got.command_code     = out_if.command_code;
        got.protocol_version = out_if.protocol_version;
        got.payload_length   = out_if.payload_length;
        got.status           = out_if.status;
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got %h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (want !== got) begin
            $display("%0t: result expected %h got %h", $time, want, got);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake on the input, result or configuration channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_request(input logic op, input logic [7:0] b);
    pending_t p;
    p.rq.opcode  = op;
    p.rq.rx_byte = b;
    p.drain      = 1'b0;
    pending_requests = {pending_requests, p};
  endtask

  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] cmd,
                             input logic [15:0] len, input bit bad_sum, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = 8'h00;
    for (i = 0; i < len + 7; i++) begin
      case (i)
        0: b = HDR_FIRST;
        1: b = HDR_SECOND;
        2: b = ver;
        3: b = cmd;
        4: b = len[15:8];
        5: b = len[7:0];
        default: begin
          if (i == len + 6) b = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
          else b = 8'($urandom_range(0, 255));
        end
      endcase
      if (i != 0 && $urandom_range(0, 99) < tick_pct)
        queue_request(OP_TICK, 8'($urandom_range(0, 255)));
      queue_request(OP_BYTE, b);
      sum = sum + b;
    end
  endtask

  task automatic queue_random_traffic(input int n);
    int         start;
    int         kind;
    int         cnt;
    int         i;
    logic [7:0] b;
    logic [15:0] len;
    start = pending_requests.size();
    while (pending_requests.size() - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 99) < 5) ? 16'($urandom_range(7, 40)) :
                                            16'($urandom_range(0, 6));
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                    $urandom_range(0, 99) < 10, 5);
      end else if (kind < 80) begin
        queue_request(OP_BYTE, HDR_FIRST);
        if (timeout_ms <= 16'd64) begin
          // partial frame left to time out
          queue_request(OP_BYTE, HDR_SECOND);
          cnt = $urandom_range(0, 4);
          for (i = 0; i < cnt; i++) queue_request(OP_BYTE, 8'($urandom_range(0, 255)));
          for (i = 0; i <= timeout_ms; i++) queue_request(OP_TICK, 8'($urandom_range(0, 255)));
        end else begin
          b = 8'($urandom_range(0, 255));
          if (b == HDR_SECOND) b = 8'h00;
          queue_request(OP_BYTE, b);
        end
      end else if (kind < 90) begin
        cnt = $urandom_range(1, 4);
        for (i = 0; i < cnt; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == HDR_FIRST) b = 8'h00;
          queue_request(OP_BYTE, b);
        end
      end else begin
        cnt = $urandom_range(1, 5);
        for (i = 0; i < cnt; i++) queue_request(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic set_timeout(input logic [15:0] ms);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= ms;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    timeout_ms = ms;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : run_test
    pending_t hold;
    int       p;
    int       i;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= 16'h0000;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // dropped bytes, ignored tick, bad second header, no rescan of 0x55
    queue_request(OP_BYTE, 8'h00);
    queue_request(OP_BYTE, 8'hFF);
    queue_request(OP_TICK, 8'hFF);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, 8'h12);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_SECOND);
    queue_frame(8'hFF, 8'h00, 16'd2, 1'b0, 0);
    queue_frame(8'h00, 8'hFF, 16'd0, 1'b0, 0);
    queue_frame(8'h5A, 8'hA5, 16'd1, 1'b1, 0);
    wait_idle();

    // zero timeout: first tick aborts, length high byte only
    set_timeout(16'h0000);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_SECOND);
    queue_request(OP_TICK, 8'h00);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_SECOND);
    queue_request(OP_BYTE, 8'h07);
    queue_request(OP_BYTE, 8'h08);
    queue_request(OP_BYTE, 8'h01);
    queue_request(OP_TICK, 8'h00);
    wait_idle();

    set_timeout(16'd1);
    queue_frame(8'h01, 8'h02, 16'd1, 1'b0, 100);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_SECOND);
    queue_request(OP_TICK, 8'h00);
    queue_request(OP_TICK, 8'h00);
    wait_idle();

    // long frame, no abort at the top setting, then a lower setting aborts
    set_timeout(16'hFFFF);
    queue_frame(8'h80, 8'h7F, 16'h0103, 1'b0, 0);
    queue_request(OP_BYTE, HDR_FIRST);
    queue_request(OP_BYTE, HDR_SECOND);
    for (i = 0; i < 4; i++) queue_request(OP_TICK, 8'h00);
    wait_idle();
    set_timeout(16'd2);
    queue_request(OP_TICK, 8'h00);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_timeout(16'hFFFE);
        1: set_timeout(16'($urandom_range(2, 20)));
        2: set_timeout(16'h0000);
        3: set_timeout(16'd1);
        4: set_timeout(TIMEOUT_RESET);
        default: set_timeout(16'($urandom_range(0, 65535)));
      endcase
      if (p == 3) no_gaps = 1'b1;
      if (p == 1) begin
        queue_random_traffic(18);
        // hold the next request until every result is back
        hold.rq.opcode  = OP_TICK;
        hold.rq.rx_byte = 8'h00;
        hold.drain      = 1'b1;
        pending_requests = {pending_requests, hold};
        queue_random_traffic(18);
      end else begin
        queue_random_traffic(36);
      end
      wait_idle();
      no_gaps = 1'b0;
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
